/* hdl/note_score_tone_synthesizer_macros.svh */
`ifndef NOTE_SCORE_TONE_SYNTHESIZER_MACROS_SVH
`define NOTE_SCORE_TONE_SYNTHESIZER_MACROS_SVH

// same-cycle implication, disabled during reset
`define NSTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsts same-cycle check failed");

// next-cycle implication, disabled during reset
`define NSTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nsts next-cycle check failed");

`endif

/* hdl/nsts_pkg.sv */
package nsts_pkg;

    // tone generator sizing
    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int MAX_OCTAVE      = 8;

    // octave handling
    localparam int OCT_W   = $clog2(MAX_OCTAVE + 1);
    localparam int OCT_MID = 4;
    localparam int UP_MAX  = MAX_OCTAVE - OCT_MID;

    // field and register widths
    localparam int KIND_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int SPB_W      = 16;
    localparam int BASE_W     = 32;
    localparam int GAIN_W     = 15;
    localparam int SAMPLES_W  = 17;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // pitch scaling and divide-by-three pipeline
    localparam int NUM_W      = 4;
    localparam int PROD_W     = BASE_W + NUM_W + UP_MAX;
    localparam int DIV_SRC_W  = (PROD_W > PHASE_BITS) ? PROD_W : PHASE_BITS;
    localparam int DIV_STEP   = 8;
    localparam int DIV_STAGES = (DIV_SRC_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W      = DIV_STAGES * DIV_STEP;

    // queue between front and back
    localparam int FQ_DEPTH = 4;
    localparam int FQ_PTR_W = $clog2(FQ_DEPTH);

    // configuration reset values
    localparam logic [SPB_W-1:0]  SPB_RESET  = SPB_W'(22050);
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(25480551);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(16384);

    // transaction kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR   = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_END    = 2'd2,
        KIND_UNUSED = 2'd3
    } t_kind;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPB  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = CFG_IDX_W'(2);

    // score characters
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_APOS   = 8'h27;
    localparam logic [CHAR_W-1:0] CH_BAR    = 8'h7C;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ONE    = 8'h31;
    localparam logic [CHAR_W-1:0] CH_SEVEN  = 8'h37;

    typedef struct packed {
        logic [SPB_W-1:0]  spb;
        logic [BASE_W-1:0] base;
        logic [GAIN_W-1:0] gain;
    } t_cfg;

    // what the back end has to do for one transaction
    typedef struct packed {
        logic commit;
        logic fresh;
        logic tick;
        logic accepted;
        logic playing;
    } t_desc;

    typedef struct packed {
        t_desc                 desc;
        logic [PHASE_BITS-1:0] inc;
    } t_fq;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_st;

    // ratio numerator per scale degree
    function automatic logic [NUM_W-1:0] ratio_num(input logic [2:0] idx);
        case (idx)
            3'd0:    return NUM_W'(1);
            3'd1:    return NUM_W'(9);
            3'd2:    return NUM_W'(5);
            3'd3:    return NUM_W'(4);
            3'd4:    return NUM_W'(3);
            3'd5:    return NUM_W'(5);
            3'd6:    return NUM_W'(15);
            default: return NUM_W'(1);
        endcase
    endfunction

    // power-of-two part of the denominator
    function automatic logic [1:0] ratio_k(input logic [2:0] idx);
        case (idx)
            3'd1, 3'd6: return 2'd3;
            3'd2:       return 2'd2;
            3'd4:       return 2'd1;
            default:    return 2'd0;
        endcase
    endfunction

    // denominator of three
    function automatic logic ratio_div3(input logic [2:0] idx);
        return (idx == 3'd3) || (idx == 3'd5);
    endfunction

    // one byte of restoring long division by three, remainder in and out
    function automatic logic [DIV_STEP+1:0] div3_byte(input logic [1:0] rem_in,
                                                      input logic [DIV_STEP-1:0] din);
        logic [1:0]          r;
        logic [2:0]          t;
        logic [DIV_STEP-1:0] q;
        r = rem_in;
        q = '0;
        for (int i = DIV_STEP - 1; i >= 0; i--) begin
            t = {r, din[i]};
            if (t >= 3'd3) begin
                q[i] = 1'b1;
                r    = 2'(t - 3'd3);
            end else begin
                r = t[1:0];
            end
        end
        return {r, q};
    endfunction

endpackage

/* hdl/nsts_if.sv */
interface nsts_in_if;
    import nsts_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output kind, output char_code, input ready);
    modport sink   (input valid, input kind, input char_code, output ready);
endinterface

interface nsts_out_if;
    import nsts_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_valid;
    logic                       accepted;
    logic                       playing;

    modport source (output valid, output sample, output sample_valid, output accepted,
                    output playing, input ready);
    modport sink   (input valid, input sample, input sample_valid, input accepted,
                    input playing, output ready);
endinterface

/* hdl/nsts_fifo.sv */
module nsts_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nsts_pkg::t_fq     i_push_data,
    input  logic              i_pop,
    output nsts_pkg::t_fq     o_pop_data,
    output nsts_pkg::t_fifo_st o_st
);
    import nsts_pkg::*;

    t_fq                 r_mem [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] r_wr;
    logic [FQ_PTR_W-1:0] r_rd;
    logic [FQ_PTR_W:0]   r_cnt;

    // status and head of queue
    assign o_st.full  = (r_cnt == (FQ_PTR_W + 1)'(FQ_DEPTH));
    assign o_st.empty = (r_cnt == '0);
    assign o_pop_data = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : r_wr + FQ_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : r_rd + FQ_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (FQ_PTR_W + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (FQ_PTR_W + 1)'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

/* hdl/nsts_front.sv */
module nsts_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    nsts_in_if.sink            i_item,
    input  nsts_pkg::t_cfg     i_cfg,
    input  nsts_pkg::t_fifo_st i_fq_st,
    output logic               o_fq_push,
    output nsts_pkg::t_fq      o_fq_data
);
    import nsts_pkg::*;

    // score state
    logic [OCT_W-1:0]     r_oct;
    logic                 r_held;
    logic [SAMPLES_W-1:0] r_left;
    logic [OCT_W-1:0]     n_oct;
    logic                 n_held;
    logic [SAMPLES_W-1:0] n_left;

    // classify stage
    logic             r_v0;
    t_desc            r_d0;
    logic             r_note0;
    logic [2:0]       r_idx0;
    logic [OCT_W-1:0] r_oct0;

    // scale and divide stages
    logic [DIV_STAGES:0] r_dv;
    t_desc               r_dd   [0:DIV_STAGES];
    logic [DIV_W-1:0]    r_x    [0:DIV_STAGES];
    logic [1:0]          r_rem  [0:DIV_STAGES-1];
    logic                r_div3 [0:DIV_STAGES-1];
    logic [DIV_W-1:0]    n_x    [1:DIV_STAGES];
    logic [1:0]          n_rem  [1:DIV_STAGES];

    logic                 adv;
    logic                 accept;
    t_desc                dsc;
    logic                 note;
    logic [DIV_W-1:0]     n_x0;
    logic                 n_div3_0;

    // the whole front moves unless its last stage is blocked by a full queue
    assign adv          = !r_dv[DIV_STAGES] || !i_fq_st.full;
    assign i_item.ready = adv;
    assign accept       = i_item.valid && adv;
    assign o_fq_push    = r_dv[DIV_STAGES] && !i_fq_st.full;
    assign o_fq_data.desc = r_dd[DIV_STAGES];
    assign o_fq_data.inc  = r_x[DIV_STAGES][PHASE_BITS-1:0];

    // classify one transaction and update score state
    always_comb begin
        logic commit;
        logic dbl;
        logic want_fresh;
        logic go_mid;
        commit     = 1'b0;
        dbl        = 1'b0;
        want_fresh = 1'b0;
        go_mid     = 1'b0;
        note       = 1'b0;
        n_oct      = r_oct;
        n_held     = r_held;
        n_left     = r_left;
        dsc        = '0;
        dsc.accepted = 1'b1;

        unique case (i_item.kind)
            KIND_CHAR: begin
                if (r_held) begin
                    if (r_left != '0) begin
                        dsc.accepted = 1'b0;
                    end else if (i_item.char_code == CH_DASH) begin
                        commit = 1'b1;
                        dbl    = 1'b1;
                    end else begin
                        commit     = 1'b1;
                        want_fresh = 1'b1;
                    end
                end else begin
                    want_fresh = 1'b1;
                end
            end
            KIND_TICK: begin
                if (r_left != '0) begin
                    dsc.tick = 1'b1;
                    n_left   = r_left - SAMPLES_W'(1);
                end
            end
            KIND_END: begin
                if (r_held && r_left != '0) begin
                    dsc.accepted = 1'b0;
                end else begin
                    commit = r_held;
                    go_mid = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // held element starts sounding
        if (commit) begin
            dsc.commit = 1'b1;
            n_held     = 1'b0;
            n_left     = dbl ? {i_cfg.spb, 1'b0} : {1'b0, i_cfg.spb};
        end

        // a character seen with nothing held
        if (want_fresh) begin
            unique case (i_item.char_code) inside
                CH_LPAREN: begin
                    if (r_oct != '0) begin
                        n_oct = r_oct - OCT_W'(1);
                    end
                end
                CH_RPAREN, CH_APOS: begin
                    if (r_oct < OCT_W'(MAX_OCTAVE)) begin
                        n_oct = r_oct + OCT_W'(1);
                    end
                end
                CH_BAR, CH_SPACE, CH_LF, CH_CR: begin
                end
                default: begin
                    dsc.fresh = 1'b1;
                    n_held    = 1'b1;
                    note      = (i_item.char_code >= CH_ONE) &&
                                (i_item.char_code <= CH_SEVEN);
                end
            endcase
        end

        if (go_mid) begin
            n_oct = OCT_W'(OCT_MID);
        end
        dsc.playing = (n_left != '0);
    end

    // base times ratio, shifted by octave; rests give zero
    always_comb begin
        logic [NUM_W-1:0]        num;
        logic [BASE_W+NUM_W-1:0] prod;
        logic [OCT_W-1:0]        up;
        logic [OCT_W-1:0]        down;
        logic [OCT_W:0]          sh;
        num  = ratio_num(r_idx0);
        prod = {{NUM_W{1'b0}}, i_cfg.base} * {{BASE_W{1'b0}}, num};
        up   = (r_oct0 > OCT_W'(OCT_MID)) ? r_oct0 - OCT_W'(OCT_MID) : '0;
        down = (r_oct0 < OCT_W'(OCT_MID)) ? OCT_W'(OCT_MID) - r_oct0 : '0;
        sh   = (OCT_W + 1)'(down) + (OCT_W + 1)'(ratio_k(r_idx0));
        n_x0     = r_note0 ? ((DIV_W'(prod) << up) >> sh) : '0;
        n_div3_0 = r_note0 && ratio_div3(r_idx0);
    end

    // divide by three, one byte per stage from the top
    always_comb begin
        logic [DIV_STEP+1:0] step;
        for (int s = 1; s <= DIV_STAGES; s++) begin
            step     = div3_byte(r_rem[s-1],
                                 r_x[s-1][DIV_W-1-(s-1)*DIV_STEP -: DIV_STEP]);
            n_x[s]   = r_x[s-1];
            n_rem[s] = r_rem[s-1];
            if (r_div3[s-1]) begin
                n_x[s][DIV_W-1-(s-1)*DIV_STEP -: DIV_STEP] = step[DIV_STEP-1:0];
                n_rem[s] = step[DIV_STEP+1:DIV_STEP];
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct  <= OCT_W'(OCT_MID);
            r_held <= 1'b0;
            r_left <= '0;
            r_v0   <= 1'b0;
            r_dv   <= '0;
        end else begin
            if (accept) begin
                r_oct  <= n_oct;
                r_held <= n_held;
                r_left <= n_left;
            end
            if (adv) begin
                r_v0 <= accept;
                r_dv <= {r_dv[DIV_STAGES-1:0], r_v0};
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d0      <= dsc;
            r_note0   <= note;
            r_idx0    <= 3'(i_item.char_code - CH_ONE);
            r_oct0    <= r_oct;
            r_dd[0]   <= r_d0;
            r_x[0]    <= n_x0;
            r_rem[0]  <= 2'd0;
            r_div3[0] <= n_div3_0;
            for (int s = 1; s <= DIV_STAGES; s++) begin
                r_dd[s] <= r_dd[s-1];
                r_x[s]  <= n_x[s];
            end
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_rem[s]  <= n_rem[s];
                r_div3[s] <= r_div3[s-1];
            end
        end
    end

endmodule

/* hdl/nsts_back.sv */
module nsts_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [nsts_pkg::GAIN_W-1:0]   i_gain,
    input  nsts_pkg::t_fifo_st            i_fq_st,
    input  nsts_pkg::t_fq                 i_fq_data,
    output logic                          o_fq_pop,
    nsts_out_if.source                    o_result
);
    import nsts_pkg::*;

    localparam int NB     = 8;
    localparam int X_W    = 16;
    localparam int X_FRAC = 15;
    localparam int QBITS  = SINE_TABLE_BITS - 2;
    localparam int MAG_W  = 15;

    // odd polynomial coefficients of the sine magnitude in Q15
    localparam logic [X_W-1:0] C1 = X_W'(51472);
    localparam logic [X_W-1:0] C3 = X_W'(21167);
    localparam logic [X_W-1:0] C5 = X_W'(2611);
    localparam logic [X_W-1:0] C7 = X_W'(153);
    localparam logic [X_W-1:0] C9 = X_W'(5);
    localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(32767);

    // c - (x2 * t >> 15)
    function automatic logic [X_W-1:0] horner(input logic [X_W-1:0] c,
                                              input logic [X_W-1:0] x2,
                                              input logic [X_W-1:0] t);
        logic [2*X_W-1:0] p;
        p = (2*X_W)'(x2) * (2*X_W)'(t);
        return c - p[X_W+X_FRAC-1:X_FRAC];
    endfunction

    // tone state
    logic [PHASE_BITS-1:0] r_held_inc;
    logic [PHASE_BITS-1:0] r_act_inc;
    logic [PHASE_BITS-1:0] r_phase;

    // pipeline
    logic [NB-1:0]              r_bv;
    t_desc                      r_bd  [0:NB-1];
    logic [SINE_TABLE_BITS-1:0] r_idx;
    logic [X_W-1:0]             r_sx  [1:5];
    logic [X_W-1:0]             r_sx2 [1:4];
    logic [X_W-1:0]             r_st  [2:5];
    logic                       r_neg [1:6];
    logic [MAG_W-1:0]           r_mag;
    logic signed [SAMPLE_W-1:0] r_sample;

    logic                       adv;
    logic                       pop;
    logic [X_W-1:0]             n_x;
    logic [X_W-1:0]             n_x2;
    logic [MAG_W-1:0]           n_mag;
    logic signed [SAMPLE_W-1:0] n_sample;

    // the back moves unless the output register holds a result not taken
    assign adv      = !r_bv[NB-1] || o_result.ready;
    assign pop      = adv && !i_fq_st.empty;
    assign o_fq_pop = pop;

    assign o_result.valid        = r_bv[NB-1];
    assign o_result.sample       = r_sample;
    assign o_result.sample_valid = r_bd[NB-1].tick;
    assign o_result.accepted     = r_bd[NB-1].accepted;
    assign o_result.playing      = r_bd[NB-1].playing;

    // quarter-wave position and its square
    always_comb begin
        logic [1:0]       quad;
        logic [QBITS-1:0] pos;
        logic [QBITS:0]   posm;
        logic [2*X_W-1:0] sq;
        quad = r_idx[SINE_TABLE_BITS-1 -: 2];
        pos  = r_idx[QBITS-1:0];
        posm = quad[0] ? ((QBITS + 1)'(1) << QBITS) - (QBITS + 1)'(pos)
                       : (QBITS + 1)'(pos);
        n_x  = X_W'(posm) << (X_FRAC - QBITS);
        sq   = (2*X_W)'(n_x) * (2*X_W)'(n_x);
        n_x2 = sq[X_W+X_FRAC-1:X_FRAC];
    end

    // final odd term with saturation
    always_comb begin
        logic [2*X_W-1:0] p;
        logic [X_W-1:0]   m;
        p     = (2*X_W)'(r_sx[5]) * (2*X_W)'(r_st[5]);
        m     = p[X_W+X_FRAC-1:X_FRAC];
        n_mag = (m > X_W'(MAG_MAX)) ? MAG_MAX : m[MAG_W-1:0];
    end

    // gain, sign, and zero for non-sounding results
    always_comb begin
        logic [2*MAG_W-1:0] g;
        logic [MAG_W-1:0]   val;
        g   = (2*MAG_W)'(r_mag) * (2*MAG_W)'(i_gain);
        val = g[MAG_W+X_FRAC-1:X_FRAC];
        n_sample = r_neg[6] ? SAMPLE_W'(0) - SAMPLE_W'(val) : SAMPLE_W'(val);
        if (!r_bd[NB-2].tick) begin
            n_sample = '0;
        end
    end

    // tone state and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_inc <= '0;
            r_act_inc  <= '0;
            r_phase    <= '0;
            r_bv       <= '0;
        end else begin
            if (pop) begin
                if (i_fq_data.desc.commit) begin
                    r_act_inc <= r_held_inc;
                    r_phase   <= '0;
                end
                if (i_fq_data.desc.fresh) begin
                    r_held_inc <= i_fq_data.inc;
                end
                if (i_fq_data.desc.tick) begin
                    r_phase <= r_phase + r_act_inc;
                end
            end
            if (adv) begin
                r_bv <= {r_bv[NB-2:0], pop};
            end
        end
    end

    // sine pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_bd[0]  <= i_fq_data.desc;
            r_idx    <= r_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
            for (int s = 1; s < NB; s++) begin
                r_bd[s] <= r_bd[s-1];
            end
            r_sx[1]  <= n_x;
            r_sx2[1] <= n_x2;
            r_neg[1] <= r_idx[SINE_TABLE_BITS-1];
            for (int s = 2; s <= 5; s++) begin
                r_sx[s] <= r_sx[s-1];
            end
            for (int s = 2; s <= 4; s++) begin
                r_sx2[s] <= r_sx2[s-1];
            end
            for (int s = 2; s <= 6; s++) begin
                r_neg[s] <= r_neg[s-1];
            end
            r_st[2]  <= horner(C7, r_sx2[1], C9);
            r_st[3]  <= horner(C5, r_sx2[2], r_st[2]);
            r_st[4]  <= horner(C3, r_sx2[3], r_st[3]);
            r_st[5]  <= horner(C1, r_sx2[4], r_st[4]);
            r_mag    <= n_mag;
            r_sample <= n_sample;
        end
    end

endmodule

/* hdl/note_score_tone_synthesizer.sv */
// Note score tone synthesizer.
// i_item carries score transactions: kind 0 a score character in char_code,
// kind 1 a sample tick, kind 2 end of score. Every accepted transaction gives
// exactly one result on o_result: a signed sample (zero unless a tick hit a
// sounding note or rest), sample_valid, accepted (low when a commit was
// refused and the transaction must be sent again) and playing.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write them only while idle, which the block does not enforce: index 0
// samples per beat, 1 base phase increment, 2 output gain. Throughput is one
// transaction per cycle unless a full queue stalls the front end; the score
// state update in the front end sets it, and every later step is a pipeline
// stage. A result passes one classify stage, one pitch scaling stage, five
// divide-by-three stages, the queue and eight tone stages.
// Synchronous reset restores the register defaults, octave 4, nothing held,
// no sound, and empties the pipelines and the queue.
// When the receiver stalls, the tone pipeline holds, the four-entry queue
// fills, then the front pipeline holds and i_item.ready drops.
`include "note_score_tone_synthesizer_macros.svh"

module note_score_tone_synthesizer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    nsts_in_if.sink                           i_item,
    nsts_out_if.source                        o_result,
    input  logic                              i_cfg_we,
    input  logic [nsts_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [nsts_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import nsts_pkg::*;

    t_cfg     r_cfg;
    t_fifo_st fq_st;
    t_fq      fq_push_data;
    t_fq      fq_pop_data;
    logic     fq_push;
    logic     fq_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spb  <= SPB_RESET;
            r_cfg.base <= BASE_RESET;
            r_cfg.gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPB:  r_cfg.spb  <= i_cfg_data[SPB_W-1:0];
                CFG_BASE: r_cfg.base <= i_cfg_data[BASE_W-1:0];
                CFG_GAIN: r_cfg.gain <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // score front end
    nsts_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_cfg     (r_cfg),
        .i_fq_st   (fq_st),
        .o_fq_push (fq_push),
        .o_fq_data (fq_push_data)
    );

    // queue between front and back
    nsts_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fq_push),
        .i_push_data (fq_push_data),
        .i_pop       (fq_pop),
        .o_pop_data  (fq_pop_data),
        .o_st        (fq_st)
    );

    // tone back end
    nsts_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_gain    (r_cfg.gain),
        .i_fq_st   (fq_st),
        .i_fq_data (fq_pop_data),
        .o_fq_pop  (fq_pop),
        .o_result  (o_result)
    );

    // front only stalls on a full queue
    `NSTS_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !i_item.ready, fq_st.full)
    // no transaction pushed into a full queue
    `NSTS_ASSERT_NOW(a_push_room, i_clk, i_rst_n, fq_push, !fq_st.full)
    // no pop from an empty queue
    `NSTS_ASSERT_NOW(a_pop_data, i_clk, i_rst_n, fq_pop, !fq_st.empty)
    // a push without a pop leaves something queued
    `NSTS_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, fq_push && !fq_pop, !fq_st.empty)

endmodule
